// File: hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, codes and microprogram for the page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // default build values
    localparam int DEF_PAGE_OFFSET_BITS = 12;
    localparam int DEF_LEVEL_COUNT      = 3;
    localparam int DEF_FRAME_COUNT      = 64;

    // fixed payload widths
    localparam int OPC_W = 1;
    localparam int VA_W  = 39;
    localparam int PA_W  = 19;
    localparam int ST_W  = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // request codes
    localparam logic [OPC_W-1:0] OPC_TRANSLATE = 1'b0;
    localparam logic [OPC_W-1:0] OPC_MAP       = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FRAMES  = 2'd2;

    // program steps
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] S_CLEAR = 3'd0;
    localparam logic [UPC_W-1:0] S_IDLE  = 3'd1;
    localparam logic [UPC_W-1:0] S_ROOT  = 3'd2;
    localparam logic [UPC_W-1:0] S_READ  = 3'd3;
    localparam logic [UPC_W-1:0] S_EVAL  = 3'd4;
    localparam logic [UPC_W-1:0] S_EMIT  = 3'd5;

    // datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_ROOT  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_STEP  = 3'd4;
    localparam logic [OP_W-1:0] OP_EMIT  = 3'd5;

    // branch conditions
    localparam int CND_W = 3;
    localparam logic [CND_W-1:0] C_ALWAYS   = 3'd0;
    localparam logic [CND_W-1:0] C_CLR_BUSY = 3'd1;
    localparam logic [CND_W-1:0] C_NO_INPUT = 3'd2;
    localparam logic [CND_W-1:0] C_FAIL     = 3'd3;
    localparam logic [CND_W-1:0] C_MORE     = 3'd4;
    localparam logic [CND_W-1:0] C_OUT_BUSY = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [UPC_W-1:0] tgt_true;
        logic [UPC_W-1:0] tgt_false;
    } t_uword;

    typedef struct packed {
        logic clr_busy;
        logic no_input;
        logic fail;
        logic more;
        logic out_busy;
    } t_flags;

    function automatic t_uword ucode(input logic [UPC_W-1:0] upc);
        t_uword w;
        case (upc)
            S_CLEAR: w = '{OP_CLEAR, C_CLR_BUSY, S_CLEAR, S_IDLE};
            S_IDLE:  w = '{OP_LOAD,  C_NO_INPUT, S_IDLE,  S_ROOT};
            S_ROOT:  w = '{OP_ROOT,  C_FAIL,     S_EMIT,  S_READ};
            S_READ:  w = '{OP_READ,  C_ALWAYS,   S_EVAL,  S_EVAL};
            S_EVAL:  w = '{OP_STEP,  C_MORE,     S_READ,  S_EMIT};
            S_EMIT:  w = '{OP_EMIT,  C_OUT_BUSY, S_EMIT,  S_IDLE};
            default: w = '{OP_LOAD,  C_ALWAYS,   S_IDLE,  S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/ptw_store.sv
// ----------------------------------------------------------------------------
// ptw_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptw_store #(
    parameter int AW = 15,
    parameter int EW = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [EW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [EW-1:0] o_rdata
);
    logic [EW-1:0] r_mem [0:(2**AW)-1];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/ptw_useq.sv
// ----------------------------------------------------------------------------
// ptw_useq
// Microprogram sequencer: step counter, control rom and conditional branch.
// ----------------------------------------------------------------------------
module ptw_useq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ptw_pkg::t_flags         i_flags,
    output logic [ptw_pkg::OP_W-1:0] o_op
);
    import ptw_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           word;
    logic             taken;

    assign word = ucode(r_upc);

    always_comb begin
        case (word.cond)
            C_ALWAYS:   taken = 1'b1;
            C_CLR_BUSY: taken = i_flags.clr_busy;
            C_NO_INPUT: taken = i_flags.no_input;
            C_FAIL:     taken = i_flags.fail;
            C_MORE:     taken = i_flags.more;
            C_OUT_BUSY: taken = i_flags.out_busy;
            default:    taken = 1'b1;
        endcase
        n_upc = taken ? word.tgt_true : word.tgt_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_op = word.op;
endmodule

// File: hdl/page_table_walk_and_map.sv
// ----------------------------------------------------------------------------
// page_table_walk_and_map
// Multi-level page table walker with an internal entry store and a bump
// frame allocator; translate or map one virtual address per request.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata bits (low first)                  | beat
//  s_axis   | in  | opcode[0], vaddr[39:1]                  | one request
//  m_axis   | out | physical_address[18:0], status[20:19]   | one result
//
//  from accept to result register a request passes the root step, a read
//  and an evaluate step per level and the emit step, fewer steps when a
//  walk stops early; each level reads the entry store once and evaluates
//  the registered entry in the next cycle; the next request is accepted
//  in the cycle after the result register loads at the earliest. after reset
//  all FRAME_COUNT*2**(PAGE_OFFSET_BITS-3) entries are swept, s_axis_tready low.
//  the result waits in an output register; a stalled m_axis holds the next
//  result in the emit step and s_axis_tready stays low.
// ----------------------------------------------------------------------------
module page_table_walk_and_map #(
    parameter int PAGE_OFFSET_BITS = ptw_pkg::DEF_PAGE_OFFSET_BITS,
    parameter int LEVEL_COUNT      = ptw_pkg::DEF_LEVEL_COUNT,
    parameter int FRAME_COUNT      = ptw_pkg::DEF_FRAME_COUNT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // opcode [0], vaddr [39:1]
    input  logic [ptw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // physical_address [18:0], status [20:19], zero [23:21]
    output logic [ptw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import ptw_pkg::*;

    localparam int IDX_W = PAGE_OFFSET_BITS - 3;
    localparam int FB    = $clog2(FRAME_COUNT);
    localparam int NFW   = $clog2(FRAME_COUNT + 1);
    localparam int EW    = FB + 1;
    localparam int AW    = FB + IDX_W;
    localparam int LW    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int SHW   = 8;
    localparam int PFW   = FB + 1 + PAGE_OFFSET_BITS;
    localparam logic [AW-1:0] CLR_LAST = AW'(FRAME_COUNT * (2 ** IDX_W) - 1);

    logic [OP_W-1:0]  op;
    t_flags           flags;

    logic             r_is_map;
    logic [VA_W-1:0]  r_va;
    logic [FB-1:0]    r_cur;
    logic [LW-1:0]    r_lvl;
    logic [ST_W-1:0]  r_status;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_clr;
    logic             r_root_present;
    logic [FB-1:0]    r_root_frame;
    logic [NFW-1:0]   r_next_free;
    logic             r_out_valid;
    logic [PA_W-1:0]  r_out_pa;
    logic [ST_W-1:0]  r_out_status;

    logic             in_accept;
    logic             full;
    logic             root_fail;
    logic             step_fail;
    logic             step_alloc;
    logic             emit_load;
    logic [SHW-1:0]   shamt;
    logic [VA_W-1:0]  va_shifted;
    logic [IDX_W-1:0] idx;
    logic [AW-1:0]    rd_addr;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [EW-1:0]    wdata;
    logic [EW-1:0]    rdata;
    logic [FB:0]      cur_inc;
    logic [PFW-1:0]   pa_full;
    logic [PFW+PA_W-1:0] pa_ext;
    logic [PA_W-1:0]  pa;

    ptw_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (op)
    );

    ptw_store #(
        .AW (AW),
        .EW (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (op == OP_READ),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (op == OP_LOAD);
    assign in_accept     = s_axis_tready && s_axis_tvalid;
    assign full          = (r_next_free == NFW'(FRAME_COUNT));

    // index field of the current level, most significant level first
    assign shamt      = SHW'(PAGE_OFFSET_BITS) + SHW'(r_lvl) * SHW'(IDX_W);
    assign va_shifted = r_va >> shamt;
    assign idx        = va_shifted[IDX_W-1:0];
    assign rd_addr    = {r_cur, idx};

    assign root_fail  = !r_root_present && (!r_is_map || full);
    assign step_fail  = !rdata[0] && (!r_is_map || full);
    assign step_alloc = (op == OP_STEP) && !rdata[0] && r_is_map && !full;

    assign we    = (op == OP_CLEAR) || step_alloc;
    assign waddr = (op == OP_CLEAR) ? r_clr : r_addr;
    assign wdata = (op == OP_CLEAR) ? '0 : {r_next_free[FB-1:0], 1'b1};

    assign emit_load = (op == OP_EMIT) && !flags.out_busy;

    always_comb begin
        flags.clr_busy = (r_clr != CLR_LAST);
        flags.no_input = !s_axis_tvalid;
        flags.fail     = ((op == OP_ROOT) && root_fail) || ((op == OP_STEP) && step_fail);
        flags.more     = (op == OP_STEP) && !step_fail && (r_lvl != '0);
        flags.out_busy = r_out_valid && !m_axis_tready;
    end

    // frame base is (frame + 1) << offset bits; the offset fills the low bits
    assign cur_inc = {1'b0, r_cur} + (FB + 1)'(1);
    assign pa_full = {cur_inc, r_va[PAGE_OFFSET_BITS-1:0]};
    assign pa_ext  = {PA_W'(0), pa_full};
    assign pa      = (!r_is_map && (r_status == ST_OK)) ? pa_ext[PA_W-1:0] : '0;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr          <= '0;
            r_root_present <= 1'b0;
            r_next_free    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if ((op == OP_CLEAR) && flags.clr_busy) begin
                r_clr <= r_clr + AW'(1);
            end
            if ((op == OP_ROOT) && !r_root_present && r_is_map && !full) begin
                r_root_present <= 1'b1;
                r_next_free    <= r_next_free + NFW'(1);
            end else if (step_alloc) begin
                r_next_free <= r_next_free + NFW'(1);
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_is_map <= s_axis_tdata[0];
            r_va     <= s_axis_tdata[VA_W:1];
            r_status <= ST_OK;
        end
        if (op == OP_ROOT) begin
            r_lvl <= LW'(LEVEL_COUNT - 1);
            if (r_root_present) begin
                r_cur <= r_root_frame;
            end else if (!r_is_map) begin
                r_status <= ST_NOT_MAPPED;
            end else if (full) begin
                r_status <= ST_NO_FRAMES;
            end else begin
                r_cur        <= r_next_free[FB-1:0];
                r_root_frame <= r_next_free[FB-1:0];
            end
        end
        if (op == OP_READ) begin
            r_addr <= rd_addr;
        end
        if (op == OP_STEP) begin
            if (rdata[0]) begin
                r_cur <= rdata[FB:1];
            end else if (!r_is_map) begin
                r_status <= ST_NOT_MAPPED;
            end else if (full) begin
                r_status <= ST_NO_FRAMES;
            end else begin
                r_cur <= r_next_free[FB-1:0];
            end
            if (r_lvl != '0) begin
                r_lvl <= r_lvl - LW'(1);
            end
        end
        if (emit_load) begin
            r_out_pa     <= pa;
            r_out_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_status, r_out_pa};

    // the allocator never hands out more frames than exist
    a_frames_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NFW'(FRAME_COUNT))
        else $error("frame allocator ran past the frame count");

    // a root exists only once a frame has been taken
    a_root_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_root_present |-> (r_next_free != '0))
        else $error("root present with no frame allocated");

    // a walk only writes over an absent entry
    a_write_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((op == OP_STEP) && we) |-> !rdata[0])
        else $error("walk overwrote a present entry");

    // a new result appears only out of the emit step
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(op == OP_EMIT))
        else $error("result raised outside the emit step");

endmodule
